/* sv/srcg_pkg.sv */
// Shared constants and types of the stepper S-curve ramp generator.
`default_nettype none

package srcg_pkg;

  // Default ramp table depth.
  localparam int unsigned RAMP_LENGTH = 128;

  // Reset value of the single step period register.
  localparam logic [15:0] SINGLE_STEP_RESET = 16'hFFFF;

  // Command word action codes.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  // Status of one word after the sequencer, waiting on the table read.
  typedef struct packed {
    logic        step;
    logic        dir;
    logic [31:0] pos;
    logic        busy;
    logic        timer;
    logic        per_mem;  // period comes from the table read
    logic        per_cfg;  // period comes from per_val
    logic [15:0] per_val;
  } stage_t;

  // Finished result word.
  typedef struct packed {
    logic [15:0] period;
    logic        step;
    logic        dir;
    logic [31:0] pos;
    logic        busy;
    logic        timer;
  } res_t;

endpackage

`default_nettype wire

/* sv/srcg_cmd_if.sv */
// Command channel interface: valid/ready plus command word fields.
`default_nettype none

interface srcg_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] target_position;
  logic [6:0]         table_index;
  logic [15:0]        table_value;

  modport source (output valid, action, target_position, table_index, table_value,
                  input ready);
  modport sink   (input valid, action, target_position, table_index, table_value,
                  output ready);
endinterface

`default_nettype wire

/* sv/srcg_res_if.sv */
// Result channel interface: valid/ready plus result word fields.
`default_nettype none

interface srcg_res_if;
  logic               valid;
  logic               ready;
  logic [15:0]        period;
  logic [14:0]        compare_value;
  logic               step_taken;
  logic               direction;
  logic signed [31:0] current_position;
  logic               busy_res;
  logic               timer_running;

  modport source (output valid, period, compare_value, step_taken, direction,
                  current_position, busy_res, timer_running, input ready);
  modport sink   (input valid, period, compare_value, step_taken, direction,
                  current_position, busy_res, timer_running, output ready);
endinterface

`default_nettype wire

/* sv/srcg_ram.sv */
// Ramp period table: one write port, one registered read port.
`default_nettype none

module srcg_ram #(
  parameter int unsigned RAMP_LENGTH = srcg_pkg::RAMP_LENGTH,
  localparam int unsigned AW = $clog2(RAMP_LENGTH)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [15:0]   wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic [15:0]        rd_data_o
);

  logic [15:0] mem [RAMP_LENGTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/srcg_seq.sv */
// Ramp sequencer: move planning, ramp state, counters and table addressing.
`default_nettype none

module srcg_seq #(
  parameter int unsigned RAMP_LENGTH = srcg_pkg::RAMP_LENGTH,
  localparam int unsigned AW = $clog2(RAMP_LENGTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          acc_i,
  input  wire logic [1:0]    action_i,
  input  wire logic [31:0]   target_i,
  input  wire logic [6:0]    index_i,
  input  wire logic [15:0]   value_i,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_wdata_i,
  output srcg_pkg::stage_t   stage_o,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [15:0]        wr_data_o
);

  localparam logic [1:0] ST_STOP  = 2'd0;
  localparam logic [1:0] ST_ACCEL = 2'd1;
  localparam logic [1:0] ST_DECEL = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  localparam logic [31:0] RL32   = 32'(RAMP_LENGTH);
  localparam logic [31:0] LAST32 = 32'(RAMP_LENGTH - 1);
  localparam logic [31:0] TWO_RL = 32'(2 * RAMP_LENGTH);

  logic [1:0]  state_q, state_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] total_q, total_d;
  logic [31:0] accel_q, accel_d;
  logic [31:0] decel_q, decel_d;
  logic        dir_q, dir_d;
  logic [31:0] pos_q, pos_d;
  logic        run_q, run_d;
  logic        timer_q, timer_d;
  logic [15:0] single_q;

  logic [31:0] cnt_inc, pos_step, delta, steps, raddr;
  logic        rd_req, step, per_cfg;

  assign cnt_inc  = cnt_q + 32'd1;
  assign pos_step = dir_q ? pos_q - 32'd1 : pos_q + 32'd1;
  assign delta    = target_i - pos_q;
  assign steps    = delta[31] ? 32'd0 - delta : delta;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    accel_d = accel_q;
    decel_d = decel_q;
    dir_d   = dir_q;
    pos_d   = pos_q;
    run_d   = run_q;
    timer_d = timer_q;
    rd_req  = 1'b0;
    raddr   = 32'd0;
    step    = 1'b0;
    per_cfg = 1'b0;
    wr_en_o = 1'b0;
    case (action_i)
      srcg_pkg::ACT_START: begin
        dir_d   = delta[31];
        total_d = steps;
        timer_d = 1'b1;
        if (steps == 32'd1) begin
          cnt_d   = 32'd0;
          accel_d = 32'd1;
          per_cfg = 1'b1;
          state_d = ST_DECEL;
          run_d   = 1'b1;
        end else if (steps != 32'd0) begin
          cnt_d   = 32'd0;
          rd_req  = 1'b1;
          state_d = ST_ACCEL;
          run_d   = 1'b1;
          if (steps <= TWO_RL) begin
            accel_d = steps >> 1;
            decel_d = steps >> 1;
          end else begin
            accel_d = RL32;
            decel_d = steps - RL32;
          end
        end
      end
      srcg_pkg::ACT_TICK: begin
        case (state_q)
          ST_ACCEL: begin
            cnt_d = cnt_inc;
            pos_d = pos_step;
            step  = 1'b1;
            if (cnt_inc < accel_q) begin
              rd_req = 1'b1;
              raddr  = cnt_inc;
            end else if (cnt_inc >= decel_q) begin
              rd_req  = 1'b1;
              raddr   = cnt_q;
              state_d = ST_DECEL;
            end else if (cnt_inc >= RL32) begin
              rd_req  = 1'b1;
              raddr   = LAST32;
              state_d = ST_RUN;
            end
          end
          ST_RUN: begin
            cnt_d = cnt_inc;
            pos_d = pos_step;
            step  = 1'b1;
            if (cnt_inc >= decel_q) begin
              rd_req  = 1'b1;
              raddr   = LAST32;
              state_d = ST_DECEL;
            end
          end
          ST_DECEL: begin
            cnt_d = cnt_inc;
            pos_d = pos_step;
            step  = 1'b1;
            if (cnt_inc < total_q) begin
              rd_req = 1'b1;
              raddr  = total_q - cnt_inc;
            end else begin
              state_d = ST_STOP;
            end
          end
          default: begin
            cnt_d   = 32'd0;
            timer_d = 1'b0;
            run_d   = 1'b0;
          end
        endcase
      end
      srcg_pkg::ACT_LOAD: begin
        wr_en_o = {25'd0, index_i} < RL32;
      end
      default: begin
      end
    endcase
  end

  // Table reads past the end saturate to the last entry.
  assign rd_addr_o = (raddr >= RL32) ? AW'(LAST32) : raddr[AW-1:0];
  assign rd_en_o   = acc_i && rd_req;
  assign wr_addr_o = AW'(index_i);
  assign wr_data_o = value_i;

  always_comb begin
    stage_o.step    = step;
    stage_o.dir     = dir_d;
    stage_o.pos     = pos_d;
    stage_o.busy    = run_d;
    stage_o.timer   = timer_d;
    stage_o.per_mem = rd_req;
    stage_o.per_cfg = per_cfg;
    stage_o.per_val = single_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_q <= srcg_pkg::SINGLE_STEP_RESET;
    end else if (cfg_we_i) begin
      single_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STOP;
      cnt_q   <= 32'd0;
      total_q <= 32'd0;
      accel_q <= 32'd0;
      decel_q <= 32'd0;
      dir_q   <= 1'b0;
      pos_q   <= 32'd0;
      run_q   <= 1'b0;
      timer_q <= 1'b0;
    end else if (acc_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      accel_q <= accel_d;
      decel_q <= decel_d;
      dir_q   <= dir_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
      timer_q <= timer_d;
    end
  end

endmodule

`default_nettype wire

/* sv/srcg_out.sv */
// Period resolve stage and output register with valid/ready flow control.
`default_nettype none

module srcg_out (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              acc_i,
  input  wire srcg_pkg::stage_t  stage_i,
  input  wire logic [15:0]       rd_data_i,
  input  wire logic              out_ready_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output srcg_pkg::res_t         res_o
);

  srcg_pkg::stage_t s1_q;
  logic             s1_valid_q;
  logic             adv;
  logic [15:0]      active_q, period_d;

  assign adv        = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_comb begin
    if (s1_q.per_mem) begin
      period_d = rd_data_i;
    end else if (s1_q.per_cfg) begin
      period_d = s1_q.per_val;
    end else begin
      period_d = active_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
      active_q    <= 16'd0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_o <= 1'b1;
        active_q    <= period_d;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= stage_i;
    end
    if (adv) begin
      res_o.period <= period_d;
      res_o.step   <= s1_q.step;
      res_o.dir    <= s1_q.dir;
      res_o.pos    <= s1_q.pos;
      res_o.busy   <= s1_q.busy;
      res_o.timer  <= s1_q.timer;
    end
  end

endmodule

`default_nettype wire

/* sv/stepper_s_curve_ramp_generator.sv */
// Top level of the stepper S-curve ramp generator.
//
// Usage:
//  - cmd_i carries command words: START (absolute target), TICK (one timer
//    update) or LOAD (write one ramp table period). A word is taken when
//    valid and ready are both high. Every word, unused action code included,
//    gives exactly one result word on res_o.
//  - cfg_we_i/cfg_wdata_i write the single step period used for one-step
//    moves; write it only while no word is in flight.
//  - res_o.valid rises once a word has passed the middle stage register and the
//    output register. One word per cycle while res_o.ready holds; state and the
//    table read register at the accepting edge, so back-to-back words are fine.
//  - The period is resolved in the second stage from the table's registered
//    read port (at most one read per word), single step period or last one.
//  - Receiver stall: the output register holds its word; one more word sits
//    in the middle stage; cmd_i.ready drops only when both are full.
//  - Reset: state STOP, position and counters zero, period zero, single
//    step period 0xFFFF, pipeline empty. The ramp table is not cleared:
//    load every entry a move will use before starting it.
`default_nettype none

module stepper_s_curve_ramp_generator #(
  parameter int unsigned RAMP_LENGTH = srcg_pkg::RAMP_LENGTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  srcg_cmd_if.sink    cmd_i,
  srcg_res_if.source  res_o,
  input  wire logic   cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(RAMP_LENGTH);

  logic             acc;
  logic             in_ready;
  srcg_pkg::stage_t stage;
  srcg_pkg::res_t   res;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [15:0]      wr_data, rd_data;

  assign acc         = cmd_i.valid && in_ready;
  assign cmd_i.ready = in_ready;

  srcg_seq #(.RAMP_LENGTH(RAMP_LENGTH)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .action_i   (cmd_i.action),
    .target_i   ($unsigned(cmd_i.target_position)),
    .index_i    (cmd_i.table_index),
    .value_i    (cmd_i.table_value),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .stage_o    (stage),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  // Table writes are gated by the accept here; reads by the sequencer.
  srcg_ram #(.RAMP_LENGTH(RAMP_LENGTH)) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (acc && wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  srcg_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .stage_i    (stage),
    .rd_data_i  (rd_data),
    .out_ready_i(res_o.ready),
    .in_ready_o (in_ready),
    .out_valid_o(res_o.valid),
    .res_o      (res)
  );

  // Compare value is half the period.
  assign res_o.period           = res.period;
  assign res_o.compare_value    = res.period[15:1];
  assign res_o.step_taken       = res.step;
  assign res_o.direction        = res.dir;
  assign res_o.current_position = $signed(res.pos);
  assign res_o.busy_res         = res.busy;
  assign res_o.timer_running    = res.timer;

endmodule

`default_nettype wire

/* sv/srcg_checker.sv */
// Port-level checks of the ramp generator, bound to the top level.
`default_nettype none

module srcg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] period_i,
  input wire logic [14:0] compare_i,
  input wire logic        step_i,
  input wire logic        busy_i,
  input wire logic        timer_i,
  input wire logic [31:0] pos_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(pos_i) && $stable(period_i))
    else $error("stalled result word changed");

  a_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> compare_i == period_i[15:1])
    else $error("compare value is not half the period");

  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && step_i |-> busy_i && timer_i)
    else $error("step issued outside a running move");

endmodule

bind stepper_s_curve_ramp_generator srcg_checker u_srcg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .period_i   (res_o.period),
  .compare_i  (res_o.compare_value),
  .step_i     (res_o.step_taken),
  .busy_i     (res_o.busy_res),
  .timer_i    (res_o.timer_running),
  .pos_i      (res_o.current_position)
);

`default_nettype wire

/* sim/srcg_ramp_checker.sv */
`timescale 1ns / 100ps
// Ramp generator checker: watches the command and result channels, predicts and compares.
module srcg_ramp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  srcg_cmd_if         cmd,
  srcg_res_if         res,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned AW = $clog2(srcg_pkg::RAMP_LENGTH);

  typedef enum logic [1:0] {
    RS_STOP  = 2'd0,
    RS_ACCEL = 2'd1,
    RS_DECEL = 2'd2,
    RS_RUN   = 2'd3
  } ramp_state_e;

  typedef struct {
    logic [15:0] period;
    logic [14:0] half;
    logic        step;
    logic        dir;
    logic [31:0] pos;
    logic        busy;
    logic        timer;
  } ramp_word_t;

  // Predicted sequencer state.
  ramp_state_e rs;
  logic [31:0] cnt, total, accel_len, decel_at, pos;
  logic        dir, busy, timer;
  logic [15:0] per, one_step_per;
  logic [15:0] table_mem [srcg_pkg::RAMP_LENGTH];

  ramp_word_t expected_words[$];
  int         errors = 0;

  task automatic note_error(string msg);
    $display("%0t ERROR %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      note_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Reads past the end clamp to the last entry.
  function automatic logic [15:0] table_at(logic [31:0] i);
    if (i >= srcg_pkg::RAMP_LENGTH) i = srcg_pkg::RAMP_LENGTH - 1;
    return table_mem[i[AW-1:0]];
  endfunction

  function automatic ramp_word_t advance_ramp(logic [1:0] act, logic [31:0] tgt,
                                              logic [6:0] idx, logic [15:0] val);
    ramp_word_t w;
    logic [31:0] delta, n;
    logic        stepped;
    stepped = 1'b0;
    case (act)
      srcg_pkg::ACT_START: begin
        delta = tgt - pos;
        dir   = delta[31];
        n     = delta[31] ? 32'd0 - delta : delta;
        total = n;
        if (n == 32'd1) begin
          cnt       = '0;
          accel_len = 32'd1;
          per       = one_step_per;
          rs        = RS_DECEL;
          busy      = 1'b1;
        end else if (n != 32'd0) begin
          cnt = '0;
          per = table_at(32'd0);
          if (n <= 2 * srcg_pkg::RAMP_LENGTH) begin
            accel_len = n >> 1;
            decel_at  = accel_len;
          end else begin
            accel_len = srcg_pkg::RAMP_LENGTH;
            decel_at  = n - srcg_pkg::RAMP_LENGTH;
          end
          rs   = RS_ACCEL;
          busy = 1'b1;
        end
        timer = 1'b1;
      end
      srcg_pkg::ACT_TICK: begin
        if (rs == RS_STOP) begin
          cnt   = '0;
          timer = 1'b0;
          busy  = 1'b0;
        end else begin
          stepped = 1'b1;
          cnt     = cnt + 32'd1;
          pos     = dir ? pos - 32'd1 : pos + 32'd1;
          case (rs)
            RS_ACCEL: begin
              if (cnt < accel_len) begin
                per = table_at(cnt);
              end else if (cnt >= decel_at) begin
                per = table_at(cnt - 32'd1);
                rs  = RS_DECEL;
              end else if (cnt >= srcg_pkg::RAMP_LENGTH) begin
                per = table_at(srcg_pkg::RAMP_LENGTH - 1);
                rs  = RS_RUN;
              end
            end
            RS_RUN: begin
              if (cnt >= decel_at) begin
                per = table_at(srcg_pkg::RAMP_LENGTH - 1);
                rs  = RS_DECEL;
              end
            end
            default: begin
              if (cnt < total) per = table_at(total - cnt);
              else rs = RS_STOP;
            end
          endcase
        end
      end
      srcg_pkg::ACT_LOAD: begin
        if (idx < srcg_pkg::RAMP_LENGTH) table_mem[AW'(idx)] = val;
      end
      default: ;
    endcase
    w.period = per;
    w.half   = per[15:1];
    w.step   = stepped;
    w.dir    = dir;
    w.pos    = pos;
    w.busy   = busy;
    w.timer  = timer;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ramp_word_t want;
    if (!rst_ni) begin
      rs           = RS_STOP;
      cnt          = '0;
      total        = '0;
      accel_len    = '0;
      decel_at     = '0;
      pos          = '0;
      dir          = 1'b0;
      busy         = 1'b0;
      timer        = 1'b0;
      per          = '0;
      one_step_per = srcg_pkg::SINGLE_STEP_RESET;
      expected_words.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (cfg_we_i) one_step_per = cfg_wdata_i;
      if (cmd.valid && cmd.ready)
        expected_words.push_back(advance_ramp(cmd.action, cmd.target_position,
                                              cmd.table_index, cmd.table_value));
      if (res.valid && res.ready) begin
        if (expected_words.size() == 0) begin
          note_error($sformatf("result word with none expected, position %0d",
                               res.current_position));
        end else begin
          want = expected_words.pop_front();
          check_field("period", 32'(res.period), 32'(want.period));
          check_field("compare_value", 32'(res.compare_value), 32'(want.half));
          check_field("step_taken", 32'(res.step_taken), 32'(want.step));
          check_field("direction", 32'(res.direction), 32'(want.dir));
          check_field("current_position", 32'(res.current_position), want.pos);
          check_field("busy_res", 32'(res.busy_res), 32'(want.busy));
          check_field("timer_running", 32'(res.timer_running), 32'(want.timer));
        end
      end
      pending_o    <= expected_words.size();
      fail_count_o <= errors;
    end
  end

endmodule

/* sim/tb_stepper_s_curve_ramp_generator.sv */
`timescale 1ns / 100ps
// Testbench top for the stepper ramp generator: stimulus, config writes and verdict.
module tb_stepper_s_curve_ramp_generator;

  // Action code the block must pass through without any effect.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Idle cycles after the last result word before a config write.
  localparam int SETTLE_CYCLES = 4;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count, pending;

  // calm set: neither side idles, words go back to back.
  bit          calm;
  // Where the motor is heading; only used to aim starts and size tick runs.
  logic [31:0] pos_track, steps_left;
  bit          dir_track;
  // Words sent that the block acts on (unused action code not counted).
  int          words_sent;

  srcg_cmd_if cmd_if ();
  srcg_res_if res_if ();

  stepper_s_curve_ramp_generator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_i       (cmd_if.sink),
    .res_o       (res_if.source),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  srcg_ramp_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd          (cmd_if),
    .res          (res_if),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop; a correct run ends far earlier.
  initial begin
    #5ms;
    $display("tb_stepper_s_curve_ramp_generator: FAIL");
    $finish;
  end

  // Per-word wait on either side: zero in calm stretches, else mostly 0..12.
  function automatic int draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Random target at distance d from where the motor is heading, either way.
  function automatic logic [31:0] aim(int unsigned d);
    return $urandom_range(0, 1) ? pos_track + d : pos_track - d;
  endfunction

  // Send one command word and hold it until accepted. valid stays high when
  // the next word follows with no gap, so it never toggles within one step.
  task automatic put_word(logic [1:0] act, logic [31:0] tgt, logic [6:0] idx,
                          logic [15:0] val);
    int          gap;
    logic [31:0] delta;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid           <= 1'b1;
    cmd_if.action          <= act;
    cmd_if.target_position <= tgt;
    cmd_if.table_index     <= idx;
    cmd_if.table_value     <= val;
    do @(posedge clk); while (!cmd_if.ready);
    if (act != ACT_UNUSED) words_sent++;
    // A zero-distance start keeps the move running but counts up from then on.
    if (act == srcg_pkg::ACT_START) begin
      delta = tgt - pos_track;
      if (delta != 32'd0) begin
        dir_track  = delta[31];
        steps_left = delta[31] ? 32'd0 - delta : delta;
      end else begin
        dir_track = 1'b0;
      end
    end else if (act == srcg_pkg::ACT_TICK && steps_left != 32'd0) begin
      steps_left--;
      pos_track = dir_track ? pos_track - 32'd1 : pos_track + 32'd1;
    end
  endtask

  task automatic start_to(logic [31:0] tgt);
    put_word(srcg_pkg::ACT_START, tgt, 7'($urandom), 16'($urandom));
  endtask

  task automatic tick_n(int n);
    repeat (n) put_word(srcg_pkg::ACT_TICK, $urandom, 7'($urandom), 16'($urandom));
  endtask

  task automatic load_entry(logic [6:0] idx, logic [15:0] val);
    put_word(srcg_pkg::ACT_LOAD, $urandom, idx, val);
  endtask

  // Whole move to the target, then a few ticks in STOP. A long move left
  // over from a far target is only partly run.
  task automatic run_move(logic [31:0] tgt, int extra);
    int n;
    start_to(tgt);
    n = (steps_left > 32'd300) ? 300 : int'(steps_left);
    tick_n(n + extra);
  endtask

  // Drop valid, wait until every expected word is back, then let the
  // pipeline empty before touching the config register.
  task automatic settle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly complete moves with random lengths; the rest aborted moves, far
  // targets, table rewrites, unused words and stray ticks.
  // mode: 0 idling on, 1 no idling, 2 idling switched per sequence.
  task automatic random_phase(int goal, int mode);
    int r;
    calm = (mode == 1);
    // One single-step move per phase so each period setting is seen.
    run_move(aim(1), 1);
    while (words_sent < goal) begin
      if (mode == 2) calm = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        run_move(aim($urandom_range(0, 40)), $urandom_range(0, 2));
      end else if (r < 67) begin
        run_move(aim($urandom_range(41, 140)), $urandom_range(0, 2));
      end else if (r < 70) begin
        // Past twice the table length: accel, run, decel.
        run_move(aim($urandom_range(257, 280)), $urandom_range(0, 2));
      end else if (r < 80) begin
        // Cut short; the next sequence's start replaces it mid-move.
        start_to(aim($urandom_range(3, 60)));
        tick_n($urandom_range(1, int'(steps_left) - 1));
      end else if (r < 86) begin
        start_to($urandom);
        tick_n($urandom_range(0, 5));
      end else if (r < 92) begin
        load_entry(7'($urandom), 16'($urandom));
      end else if (r < 96) begin
        put_word(ACT_UNUSED, $urandom, 7'($urandom), 16'($urandom));
      end else begin
        tick_n($urandom_range(1, 3));
      end
    end
    calm = 1'b0;
  endtask

  // Result side: a fresh stall before every word.
  initial begin
    int stall;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  initial begin
    int i;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    cmd_if.valid           = 1'b0;
    cmd_if.action          = srcg_pkg::ACT_TICK;
    cmd_if.target_position = '0;
    cmd_if.table_index     = '0;
    cmd_if.table_value     = '0;
    calm                   = 1'b0;
    pos_track              = '0;
    steps_left             = '0;
    dir_track              = 1'b0;
    words_sent             = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The table is not cleared by reset: fill every entry before any move.
    // Entry 0 gets the largest period, entry 1 a zero period.
    for (i = 0; i < srcg_pkg::RAMP_LENGTH; i++)
      load_entry(7'(i), (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom));

    // Directed part, single step period still at its reset value.
    start_to(32'd0);                    // zero distance from rest: timer on only
    tick_n(1);                          // tick in STOP clears the timer
    run_move(32'd1, 1);                 // one-step move
    run_move(32'hFFFF_FFFE, 1);         // down through zero, position wraps
    put_word(ACT_UNUSED, '1, '1, '1);   // unused action code, all fields high
    start_to(pos_track + 32'd10);
    tick_n(2);
    start_to(pos_track - 32'd4);        // new start replaces a running move
    tick_n(1);
    start_to(pos_track);                // zero distance while moving
    tick_n(int'(steps_left) + 1);
    start_to(pos_track + 32'h8000_0000); // most negative distance
    tick_n(2);
    start_to(32'h7FFF_FFFF);
    tick_n(1);
    start_to(32'h8000_0000);
    tick_n(1);
    load_entry(7'd127, 16'hFFFF);
    run_move(pos_track + 32'd3, 1);

    // Random part: a new period setting before each phase, extremes first.
    settle();
    write_period(16'h0000);
    run_move(aim(258), 1);              // sure to reach the constant-speed stretch
    random_phase(words_sent + 20, 0);
    settle();
    write_period(16'hFFFF);
    random_phase(words_sent + 15, 1);
    settle();
    write_period(16'($urandom));
    random_phase(words_sent + 15, 2);
    settle();
    write_period(16'h0001);
    random_phase(words_sent + 5, 0);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("tb_stepper_s_curve_ramp_generator: PASS");
    end else begin
      $display("tb_stepper_s_curve_ramp_generator: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/srcg_pkg.sv
sv/srcg_cmd_if.sv
sv/srcg_res_if.sv
sv/srcg_ram.sv
sv/srcg_seq.sv
sv/srcg_out.sv
sv/stepper_s_curve_ramp_generator.sv
sv/srcg_checker.sv
sim/srcg_ramp_checker.sv
sim/tb_stepper_s_curve_ramp_generator.sv
